### design/gbm_pkg.sv
`timescale 1ns / 1ps

package gbm_pkg;

  // ln 2 in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // floor(2^46 / ln2_q32): quotient estimate from the top bits of the exponent
  localparam logic [14:0] RECIP_LN2 = 15'd23637;
  // 32 * ln2 in Q.32, lifted to Q.49, keeps the biased exponent non-negative
  localparam logic [55:0] RANGE_OFF = 56'(LN2_Q32) << 22;

  localparam int TAYLOR_TERMS = 14;
  // the first term is r itself, the rest need a multiply and a divide
  localparam int TAYLOR_STEPS = TAYLOR_TERMS - 1;

  // biased quotient k + 32
  localparam int QUOT_W = 6;
  localparam logic [QUOT_W-1:0] QUOT_MIN = 6'd19;
  localparam logic [QUOT_W-1:0] QUOT_MAX = 6'd44;

  localparam int CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_DRIFT_RATE     = 2'd0,
    REG_TIME_STEP      = 2'd1,
    REG_TIME_STEP_ROOT = 2'd2
  } gbm_reg_t;

  localparam logic [15:0] DRIFT_RATE_RST     = 16'd0;
  localparam logic [15:0] TIME_STEP_RST      = 16'd6554;
  localparam logic [15:0] TIME_STEP_ROOT_RST = 16'd20724;

  typedef struct packed {
    logic        [31:0] price;
    logic signed [15:0] normal_draw;
    logic        [15:0] volatility;
  } gbm_in_t;

  typedef struct packed {
    logic [31:0] next_price;
    logic        saturated;
  } gbm_out_t;

  typedef struct packed {
    logic [31:0]       price;
    logic [QUOT_W-1:0] quot;
  } gbm_side_t;

endpackage

### design/gbm_exp.sv
`timescale 1ns / 1ps

module gbm_exp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [31:0]         in_r,
  input  gbm_pkg::gbm_side_t  in_side,
  output logic                out_vld,
  output logic [31:0]         out_e31,
  output gbm_pkg::gbm_side_t  out_side
);

  localparam int STEPS = gbm_pkg::TAYLOR_STEPS;

  // chain inputs of each taylor step
  logic               src_vld  [STEPS];
  logic [31:0]        src_term [STEPS];
  logic [31:0]        src_r    [STEPS];
  logic [32:0]        src_sum  [STEPS];
  gbm_pkg::gbm_side_t src_side [STEPS];

  // stage a: term * r
  logic               a_vld_r  [STEPS];
  logic [31:0]        a_v_r    [STEPS];
  logic [31:0]        a_r_r    [STEPS];
  logic [32:0]        a_sum_r  [STEPS];
  gbm_pkg::gbm_side_t a_side_r [STEPS];

  // stage b: reciprocal estimate of v / n
  logic               b_vld_r  [STEPS];
  logic [31:0]        b_v_r    [STEPS];
  logic [31:0]        b_q_r    [STEPS];
  logic [31:0]        b_r_r    [STEPS];
  logic [32:0]        b_sum_r  [STEPS];
  gbm_pkg::gbm_side_t b_side_r [STEPS];

  // stage c: corrected term, running sum
  logic               c_vld_r  [STEPS];
  logic [31:0]        c_term_r [STEPS];
  logic [31:0]        c_r_r    [STEPS];
  logic [32:0]        c_sum_r  [STEPS];
  gbm_pkg::gbm_side_t c_side_r [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [63:0] RECIP_W = (64'd1 << 32) / (j + 2);
    localparam logic [31:0] RECIP   = RECIP_W[31:0];
    localparam logic [31:0] TERM_N  = 32'(j + 2);

    logic [63:0] a_prod_nxt;
    logic [63:0] b_prod_nxt;
    logic [31:0] c_qn_nxt;
    logic [31:0] c_rem_nxt;
    logic [31:0] c_term_nxt;

    if (j == 0) begin : g_first
      // t1 = r, sum starts at 1 + r
      assign src_vld[j]  = in_vld;
      assign src_term[j] = in_r;
      assign src_r[j]    = in_r;
      assign src_sum[j]  = {1'b1, in_r};
      assign src_side[j] = in_side;
    end else begin : g_chain
      assign src_vld[j]  = c_vld_r[j-1];
      assign src_term[j] = c_term_r[j-1];
      assign src_r[j]    = c_r_r[j-1];
      assign src_sum[j]  = c_sum_r[j-1];
      assign src_side[j] = c_side_r[j-1];
    end

    assign a_prod_nxt = 64'(src_term[j]) * 64'(src_r[j]);
    assign b_prod_nxt = 64'(a_v_r[j]) * 64'(RECIP);
    // estimate is exact or one short
    assign c_qn_nxt   = 32'(b_q_r[j] * TERM_N);
    assign c_rem_nxt  = b_v_r[j] - c_qn_nxt;
    assign c_term_nxt = b_q_r[j] + 32'(c_rem_nxt >= TERM_N);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r[j] <= 1'b0;
        b_vld_r[j] <= 1'b0;
        c_vld_r[j] <= 1'b0;
      end else if (en) begin
        a_vld_r[j] <= src_vld[j];
        b_vld_r[j] <= a_vld_r[j];
        c_vld_r[j] <= b_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_v_r[j]    <= a_prod_nxt[63:32];
        a_r_r[j]    <= src_r[j];
        a_sum_r[j]  <= src_sum[j];
        a_side_r[j] <= src_side[j];

        b_v_r[j]    <= a_v_r[j];
        b_q_r[j]    <= b_prod_nxt[63:32];
        b_r_r[j]    <= a_r_r[j];
        b_sum_r[j]  <= a_sum_r[j];
        b_side_r[j] <= a_side_r[j];

        c_term_r[j] <= c_term_nxt;
        c_r_r[j]    <= b_r_r[j];
        c_sum_r[j]  <= b_sum_r[j] + 33'(c_term_nxt);
        c_side_r[j] <= b_side_r[j];
      end
    end
  end

  assign out_vld  = c_vld_r[STEPS-1];
  assign out_e31  = c_sum_r[STEPS-1][32:1];
  assign out_side = c_side_r[STEPS-1];

  // r is non-negative, so the series never drops below one
  a_exp_at_least_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> out_e31[31])
    else $error("exponential below one");

endmodule

### design/gbm_price_step.sv
`timescale 1ns / 1ps

// channel  dir  handshake                    beat
// in_      in   in_valid / in_ready          gbm_in_t: price, normal_draw, volatility
// out_     out  out_valid / out_ready        gbm_out_t: next_price, saturated
// cfg      in   psel, penable, pwrite, pready drift_rate, time_step, time_step_root
//
// one beat enters per cycle unless stalled; it passes s1 to s7, the series, p1 and the output register
// the bulk of the pipe is the taylor series: thirteen steps of three stages each
// (term multiply, reciprocal multiply for the divide, correction and sum)
// reset is synchronous and clears only the valid bits and the config registers
// on a stall the whole pipe holds, only when the product stage and the output
// register are both full; bubbles still move while a result waits

module gbm_price_step (
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_ready,
  input  gbm_pkg::gbm_in_t           in_data,

  output logic                       out_valid,
  input  logic                       out_ready,
  output gbm_pkg::gbm_out_t          out_data,

  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // ---------------------------------------------------------------- config
  logic [15:0] drift_rate_r;
  logic [15:0] time_step_r;
  logic [15:0] time_step_root_r;
  logic        cfg_wr;
  gbm_pkg::gbm_reg_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = gbm_pkg::gbm_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_rate_r     <= gbm_pkg::DRIFT_RATE_RST;
      time_step_r      <= gbm_pkg::TIME_STEP_RST;
      time_step_root_r <= gbm_pkg::TIME_STEP_ROOT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        gbm_pkg::REG_DRIFT_RATE:     drift_rate_r     <= pwdata[15:0];
        gbm_pkg::REG_TIME_STEP:      time_step_r      <= pwdata[15:0];
        gbm_pkg::REG_TIME_STEP_ROOT: time_step_root_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      gbm_pkg::REG_DRIFT_RATE:     prdata = {16'd0, drift_rate_r};
      gbm_pkg::REG_TIME_STEP:      prdata = {16'd0, time_step_r};
      gbm_pkg::REG_TIME_STEP_ROOT: prdata = {16'd0, time_step_root_r};
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  logic p1_vld_r;
  logic out_vld_r;
  logic en;

  // the pipe moves unless the product stage cannot hand over
  assign en       = !p1_vld_r || !out_vld_r || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------- s1: sigma^2, sigma*root
  logic               s1_vld_r;
  logic [31:0]        s1_price_r;
  logic signed [15:0] s1_z_r;
  logic [31:0]        s1_sig2_r;
  logic [31:0]        s1_sr_r;
  logic [31:0]        s1_sig2_nxt;
  logic [31:0]        s1_sr_nxt;

  assign s1_sig2_nxt = 32'(in_data.volatility) * 32'(in_data.volatility);
  assign s1_sr_nxt   = 32'(in_data.volatility) * 32'(time_step_root_r);

  // ---------------------------------------------------------------- s2: drift, diffusion
  logic               s2_vld_r;
  logic [31:0]        s2_price_r;
  logic signed [33:0] s2_drift_r;
  logic signed [48:0] s2_zt_r;
  logic signed [33:0] s2_drift_nxt;
  logic signed [48:0] s2_zt_nxt;

  // mu * 2^17 - sigma^2, both in Q.33
  assign s2_drift_nxt = $signed({drift_rate_r[15], drift_rate_r, 17'd0})
                      - $signed({2'b00, s1_sig2_r});
  assign s2_zt_nxt    = 49'($signed({1'b0, s1_sr_r})) * 49'(s1_z_r);

  // ---------------------------------------------------------------- s3: drift * dt
  logic               s3_vld_r;
  logic [31:0]        s3_price_r;
  logic signed [50:0] s3_a_r;
  logic signed [48:0] s3_zt_r;
  logic signed [50:0] s3_a_nxt;

  assign s3_a_nxt = 51'(s2_drift_r) * 51'($signed({1'b0, time_step_r}));

  // ---------------------------------------------------------------- s4: exponent in Q.49, floor to Q.32
  logic        s4_vld_r;
  logic [31:0] s4_price_r;
  logic [37:0] s4_u_r;
  logic [55:0] s4_sum_nxt;

  // biased by 32 ln2 so the floor is a plain slice
  assign s4_sum_nxt = 56'(s3_a_r) + (56'(s3_zt_r) << 5) + gbm_pkg::RANGE_OFF;

  // ---------------------------------------------------------------- s5: quotient estimate
  logic                       s5_vld_r;
  logic [31:0]                s5_price_r;
  logic [37:0]                s5_u_r;
  logic [gbm_pkg::QUOT_W-1:0] s5_qe_r;
  logic [26:0]                s5_prod_nxt;

  assign s5_prod_nxt = 27'(s4_u_r[37:26]) * 27'(gbm_pkg::RECIP_LN2);

  // ---------------------------------------------------------------- s6: remainder
  logic                       s6_vld_r;
  logic [31:0]                s6_price_r;
  logic [gbm_pkg::QUOT_W-1:0] s6_qe_r;
  logic [32:0]                s6_r0_r;
  logic [37:0]                s6_diff_nxt;

  assign s6_diff_nxt = s5_u_r - 38'(s5_qe_r) * 38'(gbm_pkg::LN2_Q32);

  // ---------------------------------------------------------------- s7: correction
  logic               s7_vld_r;
  gbm_pkg::gbm_side_t s7_side_r;
  logic [31:0]        s7_r_r;
  logic               s7_fix_nxt;
  logic [32:0]        s7_sub_nxt;

  // the estimate is exact or one short
  assign s7_fix_nxt = s6_r0_r >= {1'b0, gbm_pkg::LN2_Q32};
  assign s7_sub_nxt = s6_r0_r - {1'b0, gbm_pkg::LN2_Q32};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_price_r <= in_data.price;
      s1_z_r     <= in_data.normal_draw;
      s1_sig2_r  <= s1_sig2_nxt;
      s1_sr_r    <= s1_sr_nxt;

      s2_price_r <= s1_price_r;
      s2_drift_r <= s2_drift_nxt;
      s2_zt_r    <= s2_zt_nxt;

      s3_price_r <= s2_price_r;
      s3_a_r     <= s3_a_nxt;
      s3_zt_r    <= s2_zt_r;

      s4_price_r <= s3_price_r;
      s4_u_r     <= s4_sum_nxt[54:17];

      s5_price_r <= s4_price_r;
      s5_u_r     <= s4_u_r;
      s5_qe_r    <= s5_prod_nxt[25:20];

      s6_price_r <= s5_price_r;
      s6_qe_r    <= s5_qe_r;
      s6_r0_r    <= s6_diff_nxt[32:0];

      s7_side_r.price <= s6_price_r;
      if (s7_fix_nxt) begin
        s7_side_r.quot <= s6_qe_r + 6'd1;
        s7_r_r         <= s7_sub_nxt[31:0];
      end else begin
        s7_side_r.quot <= s6_qe_r;
        s7_r_r         <= s6_r0_r[31:0];
      end
    end
  end

  // ---------------------------------------------------------------- taylor series
  logic               ex_vld;
  logic [31:0]        ex_e31;
  gbm_pkg::gbm_side_t ex_side;

  gbm_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s7_vld_r),
    .in_r     (s7_r_r),
    .in_side  (s7_side_r),
    .out_vld  (ex_vld),
    .out_e31  (ex_e31),
    .out_side (ex_side)
  );

  // ---------------------------------------------------------------- p1: price * e
  logic [63:0]                p1_prod_r;
  logic [gbm_pkg::QUOT_W-1:0] p1_quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= ex_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_prod_r <= 64'(ex_side.price) * 64'(ex_e31);
      p1_quot_r <= ex_side.quot;
    end
  end

  // ---------------------------------------------------------------- output: scale by 2^k, round, clip
  logic [gbm_pkg::QUOT_W-1:0] sh_nxt;
  logic [63:0]                shifted_nxt;
  logic [46:0]                rnd_nxt;
  logic [45:0]                res_nxt;
  logic                       sat_nxt;
  gbm_pkg::gbm_out_t          out_data_r;

  // shift by 31 - k less one, the last bit goes to rounding
  assign sh_nxt      = 6'd62 - p1_quot_r;
  assign shifted_nxt = p1_prod_r >> sh_nxt;
  assign rnd_nxt     = shifted_nxt[46:0] + 47'd1;
  assign res_nxt     = rnd_nxt[46:1];
  assign sat_nxt     = |res_nxt[45:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (p1_vld_r && en) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_vld_r && en) begin
      out_data_r.next_price <= sat_nxt ? 32'hFFFF_FFFF : res_nxt[31:0];
      out_data_r.saturated  <= sat_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- checks
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    s7_vld_r |-> (s7_side_r.quot >= gbm_pkg::QUOT_MIN) &&
                 (s7_side_r.quot <= gbm_pkg::QUOT_MAX))
    else $error("range reduction quotient out of bounds");

  a_rem_below_ln2: assert property (@(posedge clk) disable iff (!rst_n)
    s7_vld_r |-> (s7_r_r < gbm_pkg::LN2_Q32))
    else $error("range reduction remainder not below ln2");

  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.saturated) |-> (out_data_r.next_price == 32'hFFFF_FFFF))
    else $error("saturated result not clipped");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (p1_vld_r && out_vld_r))
    else $error("stall dropped a beat");

endmodule
